// ===== rtl/chip8_cpu_subset_step_unit_assert.svh =====
// assertion macros of the rtl top module of the chip-8 step unit
// expects signals named clk and rst in the including module
`ifndef CHIP8_CPU_SUBSET_STEP_UNIT_ASSERT_SVH
`define CHIP8_CPU_SUBSET_STEP_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define C8_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c8 same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define C8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c8 next-cycle check failed");

`endif

// ===== rtl/c8_pkg.sv =====
// shared types and constants of the chip-8 step unit
// no dependencies
package c8_pkg;

  localparam int MEMORY_BYTES_DEF  = 4096;
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam logic [11:0] START_ADDR_RESET = 12'd512;

  // operation codes of an input beat
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // instruction encodings
  localparam logic [15:0] INS_CLS   = 16'h00E0;
  localparam logic [3:0]  GRP_JUMP  = 4'h1;
  localparam logic [3:0]  GRP_SET   = 4'h6;
  localparam logic [3:0]  GRP_ADD   = 4'h7;
  localparam logic [3:0]  GRP_INDEX = 4'hA;
  localparam logic [3:0]  GRP_DRAW  = 4'hD;
  localparam logic [3:0]  VF_INDEX  = 4'hF;

  // configuration register byte address
  localparam logic [1:0] REG_START_ADDR = 2'd0;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_W1,
    ST_LD_W2,
    ST_LD_WR,
    ST_FE_W1,
    ST_FE_W2,
    ST_FE_A,
    ST_FE_HI,
    ST_FE_LO,
    ST_ADD,
    ST_IDX_W1,
    ST_IDX_W2,
    ST_IDX_SET,
    ST_DR_RY,
    ST_DR_VY,
    ST_DR_W1,
    ST_DR_W2,
    ST_DR_SET,
    ST_DR_RD,
    ST_DR_UPD,
    ST_RR
  } c8_state_t;

endpackage

// ===== rtl/c8_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/c8_wrap.sv =====
// two-stage remainder by a constant divisor via reciprocal multiply
// no dependencies; value and quotient are registered, then the remainder
module c8_wrap #(
  parameter int DIVISOR = 4096,
  parameter int IN_W    = 12
) (
  input  logic                       clk,
  input  logic [IN_W-1:0]            value,
  output logic [$clog2(DIVISOR)-1:0] remainder
);

  localparam int OUT_W = $clog2(DIVISOR);
  localparam int SHIFT = IN_W + OUT_W + 1;
  localparam int RW    = IN_W + 2;
  localparam int PW    = IN_W + RW;
  localparam int DW    = OUT_W + 1;
  localparam int QW    = IN_W + DW;
  localparam longint RECIP_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

  logic [PW-1:0]   prod;
  logic [IN_W-1:0] quot;
  logic [IN_W-1:0] v_q;
  logic [IN_W-1:0] q_q;
  logic [QW-1:0]   qd;
  logic [QW-1:0]   diff;

  // floor(value / divisor) is exact for every value of IN_W bits
  assign prod = PW'(value) * PW'(RECIP);
  assign quot = IN_W'(prod >> SHIFT);
  assign qd   = QW'(q_q) * QW'(DIV_C);
  assign diff = QW'(v_q) - qd;

  always_ff @(posedge clk) begin
    v_q       <= value;
    q_q       <= quot;
    remainder <= OUT_W'(diff);
  end

endmodule

// ===== rtl/chip8_cpu_subset_step_unit.sv =====
// top level of the chip-8 subset step unit: sequencer, registers, apb port
// depends on c8_pkg, c8_ram, c8_wrap and chip8_cpu_subset_step_unit_assert.svh
//
//  port group      | dir | handshake
//  ----------------+-----+------------------------------------------------
//  command beat    | in  | start && !busy; operation, address, data, row
//  result beat     | out | done strobe, one cycle; status .. collision
//  register access | in  | apb write when psel && penable && pwrite
//
// load: ld_w1, ld_w2, ld_wr; row read: rr; unused code: ends in idle;
// execute: fe_w1 to fe_lo (clear, jump, set, unknown end there), then add,
// idx_w1 to idx_set (set index) or dr_ry to dr_set plus dr_rd, dr_upd per
// sprite row (draw: one program ram read, one frame ram read-modify-write).
// after reset a clearing pass zeroes all MEMORY_BYTES program ram bytes,
// busy high meanwhile; register file and frame rows clear at once via valid
// bits. results cannot be stalled: done is a single-cycle strobe.
`include "chip8_cpu_subset_step_unit_assert.svh"

module chip8_cpu_subset_step_unit #(
  parameter int MEMORY_BYTES  = c8_pkg::MEMORY_BYTES_DEF,
  parameter int SCREEN_WIDTH  = c8_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = c8_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [4:0]  row,
  output logic        done,
  output logic        status,
  output logic [15:0] opcode_seen,
  output logic [11:0] program_counter,
  output logic [63:0] row_bits,
  output logic        collision,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  c8_pkg::c8_state_t state, state_next;

  // control state
  logic [AW-1:0]            sweep;
  logic [11:0]              pc;
  logic [11:0]              start_addr;
  logic [AW-1:0]            idx;
  logic [15:0]              vvld;
  logic [SCREEN_HEIGHT-1:0] fvld;
  logic                     vf0;

  // datapath registers
  logic [1:0]    op_q;
  logic [7:0]    data_q;
  logic [11:0]   wrap_src;
  logic [AW-1:0] pm1;
  logic [7:0]    hi;
  logic [15:0]   opc;
  logic [7:0]    vx;
  logic [7:0]    vy;
  logic [XW-1:0] px0;
  logic [YW-1:0] py;
  logic [3:0]    cnt;
  logic [AW-1:0] sa;
  logic          vrd_ok;
  logic          frd_ok;
  logic          status_q;
  logic [15:0]   opcode_q;
  logic [63:0]   bits_q;

  // memory ports
  logic          pm_we;
  logic [AW-1:0] pm_waddr, pm_raddr;
  logic [7:0]    pm_wdata, pm_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata;
  logic          f_we;
  logic [YW-1:0] f_waddr, f_raddr;
  logic [63:0]   f_wdata, f_rdata;

  // wrap unit outputs
  logic [AW-1:0] wm_out;
  logic [XW-1:0] ww_out;
  logic [YW-1:0] wh_out;

  // decode and draw helpers
  logic [15:0]   op_word;
  logic [15:0]   ins;
  logic [3:0]    x_f, y_f, n_f;
  logic [7:0]    nn_f;
  logic [11:0]   nnn_f;
  logic [7:0]    vval;
  logic [7:0]    add_sum;
  logic [63:0]   frame_old;
  logic [63:0]   mask;
  logic [63:0]   row_new;
  logic          hit;
  logic [AW:0]   wm_inc, sa_inc;
  logic [AW-1:0] pm1_val, sa_next;
  logic [YW:0]   py_inc;
  logic [YW-1:0] py_next;
  logic          row_ok;
  logic          finish;
  logic          unknown;
  logic          cfg_wr;

  assign busy            = (state != c8_pkg::ST_IDLE);
  assign program_counter = pc;
  assign collision       = vf0;
  assign status          = status_q;
  assign opcode_seen     = opcode_q;
  assign row_bits        = bits_q;
  assign pready          = 1'b1;
  assign cfg_wr          = psel && penable && pwrite && (paddr == c8_pkg::REG_START_ADDR);
  assign prdata          = (paddr == c8_pkg::REG_START_ADDR) ? {20'd0, start_addr} : 32'd0;

  // instruction fields: live from ram in the last fetch cycle, held after
  assign op_word = {hi, pm_rdata};
  assign ins     = (state == c8_pkg::ST_FE_LO) ? op_word : opc;
  assign x_f     = ins[11:8];
  assign y_f     = ins[7:4];
  assign n_f     = ins[3:0];
  assign nn_f    = ins[7:0];
  assign nnn_f   = ins[11:0];

  // registers never written read as zero
  assign vval    = vrd_ok ? v_rdata : 8'd0;
  assign add_sum = vval + nn_f;
  assign frame_old = frd_ok ? f_rdata : 64'd0;

  // wrapped address increments
  assign wm_inc  = {1'b0, wm_out} + (AW+1)'(1);
  assign pm1_val = (wm_inc == (AW+1)'(MEMORY_BYTES)) ? '0 : AW'(wm_inc);
  assign sa_inc  = {1'b0, sa} + (AW+1)'(1);
  assign sa_next = (sa_inc == (AW+1)'(MEMORY_BYTES)) ? '0 : AW'(sa_inc);
  assign py_inc  = {1'b0, py} + (YW+1)'(1);
  assign py_next = (py_inc == (YW+1)'(SCREEN_HEIGHT)) ? '0 : YW'(py_inc);
  assign row_ok  = ({2'b00, row} < 7'(SCREEN_HEIGHT));

  // pixel mask of one sprite byte, columns wrap at the screen width
  always_comb begin
    logic [XW:0]   sum;
    logic [XW-1:0] px;
    mask = '0;
    for (int c = 0; c < 8; c++) begin
      sum = {1'b0, px0} + (XW+1)'(c);
      if (sum >= (XW+1)'(SCREEN_WIDTH)) begin
        sum = sum - (XW+1)'(SCREEN_WIDTH);
      end
      px = XW'(sum);
      if (pm_rdata[7-c]) begin
        mask[6'd63 - 6'(px)] = 1'b1;
      end
    end
  end

  assign hit     = |(frame_old & mask);
  assign row_new = frame_old ^ mask;

  // next state and memory control
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unknown    = 1'b0;
    pm_we      = 1'b0;
    pm_waddr   = wm_out;
    pm_wdata   = data_q;
    pm_raddr   = sa;
    v_we       = 1'b0;
    v_waddr    = x_f;
    v_wdata    = nn_f;
    v_raddr    = x_f;
    f_we       = 1'b0;
    f_waddr    = py;
    f_wdata    = row_new;
    f_raddr    = py;
    unique case (state)
      c8_pkg::ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = sweep;
        pm_wdata = 8'd0;
        if (sweep == AW'(MEMORY_BYTES - 1)) begin
          state_next = c8_pkg::ST_IDLE;
        end
      end
      c8_pkg::ST_IDLE: begin
        f_raddr = YW'(row);
        if (start) begin
          unique case (operation)
            c8_pkg::OP_LOAD: state_next = c8_pkg::ST_LD_W1;
            c8_pkg::OP_EXEC: state_next = c8_pkg::ST_FE_W1;
            c8_pkg::OP_READ: begin
              if (row_ok) begin
                state_next = c8_pkg::ST_RR;
              end else begin
                finish = 1'b1;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      c8_pkg::ST_LD_W1:  state_next = c8_pkg::ST_LD_W2;
      c8_pkg::ST_LD_W2:  state_next = c8_pkg::ST_LD_WR;
      c8_pkg::ST_LD_WR: begin
        pm_we      = 1'b1;
        finish     = 1'b1;
        state_next = c8_pkg::ST_IDLE;
      end
      c8_pkg::ST_FE_W1:  state_next = c8_pkg::ST_FE_W2;
      c8_pkg::ST_FE_W2:  state_next = c8_pkg::ST_FE_A;
      c8_pkg::ST_FE_A: begin
        pm_raddr   = wm_out;
        state_next = c8_pkg::ST_FE_HI;
      end
      c8_pkg::ST_FE_HI: begin
        pm_raddr   = pm1;
        state_next = c8_pkg::ST_FE_LO;
      end
      c8_pkg::ST_FE_LO: begin
        state_next = c8_pkg::ST_IDLE;
        if (op_word == c8_pkg::INS_CLS) begin
          finish = 1'b1;
        end else begin
          unique case (op_word[15:12])
            c8_pkg::GRP_JUMP: finish = 1'b1;
            c8_pkg::GRP_SET: begin
              v_we   = 1'b1;
              finish = 1'b1;
            end
            c8_pkg::GRP_ADD:   state_next = c8_pkg::ST_ADD;
            c8_pkg::GRP_INDEX: state_next = c8_pkg::ST_IDX_W1;
            c8_pkg::GRP_DRAW:  state_next = c8_pkg::ST_DR_RY;
            default: begin
              unknown = 1'b1;
              finish  = 1'b1;
            end
          endcase
        end
      end
      c8_pkg::ST_ADD: begin
        v_we       = 1'b1;
        v_wdata    = add_sum;
        finish     = 1'b1;
        state_next = c8_pkg::ST_IDLE;
      end
      c8_pkg::ST_IDX_W1:  state_next = c8_pkg::ST_IDX_W2;
      c8_pkg::ST_IDX_W2:  state_next = c8_pkg::ST_IDX_SET;
      c8_pkg::ST_IDX_SET: begin
        finish     = 1'b1;
        state_next = c8_pkg::ST_IDLE;
      end
      c8_pkg::ST_DR_RY: begin
        v_raddr    = y_f;
        state_next = c8_pkg::ST_DR_VY;
      end
      c8_pkg::ST_DR_VY: state_next = c8_pkg::ST_DR_W1;
      c8_pkg::ST_DR_W1: state_next = c8_pkg::ST_DR_W2;
      c8_pkg::ST_DR_W2: state_next = c8_pkg::ST_DR_SET;
      c8_pkg::ST_DR_SET: begin
        // coordinates are already read, now clear vf
        v_we    = 1'b1;
        v_waddr = c8_pkg::VF_INDEX;
        v_wdata = 8'd0;
        if (n_f == 4'd0) begin
          finish     = 1'b1;
          state_next = c8_pkg::ST_IDLE;
        end else begin
          state_next = c8_pkg::ST_DR_RD;
        end
      end
      c8_pkg::ST_DR_RD: state_next = c8_pkg::ST_DR_UPD;
      c8_pkg::ST_DR_UPD: begin
        f_we    = 1'b1;
        v_we    = hit;
        v_waddr = c8_pkg::VF_INDEX;
        v_wdata = 8'd1;
        if ((cnt + 4'd1) == n_f) begin
          finish     = 1'b1;
          state_next = c8_pkg::ST_IDLE;
        end else begin
          state_next = c8_pkg::ST_DR_RD;
        end
      end
      c8_pkg::ST_RR: begin
        finish     = 1'b1;
        state_next = c8_pkg::ST_IDLE;
      end
      default: state_next = c8_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // architectural control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      pc         <= c8_pkg::START_ADDR_RESET;
      start_addr <= c8_pkg::START_ADDR_RESET;
      idx        <= '0;
      vvld       <= '0;
      fvld       <= '0;
      vf0        <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= finish;
      if (state == c8_pkg::ST_CLEAR) begin
        sweep <= sweep + AW'(1);
      end
      if (state == c8_pkg::ST_FE_LO) begin
        if (op_word[15:12] == c8_pkg::GRP_JUMP) begin
          pc <= op_word[11:0];
        end else begin
          pc <= pc + 12'd2;
        end
        if (op_word == c8_pkg::INS_CLS) begin
          fvld <= '0;
        end
      end
      if (state == c8_pkg::ST_IDX_SET) begin
        idx <= wm_out;
      end
      if (v_we) begin
        vvld[v_waddr] <= 1'b1;
        if (v_waddr == c8_pkg::VF_INDEX) begin
          vf0 <= v_wdata[0];
        end
      end
      if (f_we) begin
        fvld[f_waddr] <= 1'b1;
      end
      // the user must make register writes only while idle; the block does not enforce it
      if (cfg_wr) begin
        start_addr <= pwdata[11:0];
        pc         <= pwdata[11:0];
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    vrd_ok <= vvld[v_raddr];
    frd_ok <= fvld[f_raddr];
    unique case (state)
      c8_pkg::ST_IDLE: begin
        if (start) begin
          op_q     <= operation;
          data_q   <= data;
          wrap_src <= (operation == c8_pkg::OP_LOAD) ? address : pc;
        end
      end
      c8_pkg::ST_FE_A:  pm1 <= pm1_val;
      c8_pkg::ST_FE_HI: hi  <= pm_rdata;
      c8_pkg::ST_FE_LO: begin
        opc      <= op_word;
        wrap_src <= op_word[11:0];
        vx       <= vval;
      end
      c8_pkg::ST_DR_RY: vx <= vval;
      c8_pkg::ST_DR_VY: vy <= vval;
      c8_pkg::ST_DR_SET: begin
        px0 <= ww_out;
        py  <= wh_out;
        cnt <= 4'd0;
        sa  <= idx;
      end
      c8_pkg::ST_DR_UPD: begin
        cnt <= cnt + 4'd1;
        sa  <= sa_next;
        py  <= py_next;
      end
      default: begin
      end
    endcase
    if (finish) begin
      status_q <= unknown;
      if (state == c8_pkg::ST_IDLE || op_q != c8_pkg::OP_EXEC) begin
        opcode_q <= 16'd0;
      end else begin
        opcode_q <= ins;
      end
      bits_q <= (state == c8_pkg::ST_RR) ? frame_old : 64'd0;
    end
  end

  // address reduction modulo the memory size
  c8_wrap #(.DIVISOR(MEMORY_BYTES), .IN_W(12)) u_wrap_mem (
    .clk       (clk),
    .value     (wrap_src),
    .remainder (wm_out)
  );

  // draw coordinates modulo the screen size
  c8_wrap #(.DIVISOR(SCREEN_WIDTH), .IN_W(8)) u_wrap_x (
    .clk       (clk),
    .value     (vx),
    .remainder (ww_out)
  );

  c8_wrap #(.DIVISOR(SCREEN_HEIGHT), .IN_W(8)) u_wrap_y (
    .clk       (clk),
    .value     (vy),
    .remainder (wh_out)
  );

  // program memory
  c8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_prog_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // byte registers v0..vf
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // framebuffer, one 64-bit row per entry
  c8_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  `C8_ASSERT_SAME(a_done_when_idle, done, state == c8_pkg::ST_IDLE)
  `C8_ASSERT_NEXT(a_long_op_busy, start && !busy && (operation == c8_pkg::OP_LOAD || operation == c8_pkg::OP_EXEC), busy)
  `C8_ASSERT_SAME(a_unknown_no_bits, done && status, row_bits == 64'd0)
  `C8_ASSERT_SAME(a_clear_quiet, state == c8_pkg::ST_CLEAR, !done && !f_we && !v_we)

endmodule
